/* rtl/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg
// Shared constants, types and helpers of the star point translate/rotate block.
// ----------------------------------------------------------------------------
package spt_pkg;

   localparam int STAR_COUNT    = 8192;
   localparam int VIEW_DISTANCE = 100;
   localparam int STAR_ADDR_W   = $clog2(STAR_COUNT);
   localparam int FRAC_BITS     = 14;

   // Number of register stages from the translated position to the result.
   localparam int LINE_DEPTH    = 19;
   // Stages after the rotation chain needed to line up with the brightness.
   localparam int ROT_PAD       = 13;
   localparam int SQRT_STAGES   = 12;
   localparam int DIV_STAGES    = 4;

   // Brightness numerator: VIEW_DISTANCE * 255 * 2^13.
   localparam logic [29:0] BRIGHT_NUM = 30'(VIEW_DISTANCE * 255 * 8192);
   // Respawn threshold on the squared distance: (100 * 2^14)^2.
   localparam logic [47:0] RESPAWN_SQ = 48'd2684354560000;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   localparam logic [2:0] REG_MOVE_X = 3'd0;
   localparam logic [2:0] REG_MOVE_Y = 3'd1;
   localparam logic [2:0] REG_MOVE_Z = 3'd2;
   localparam logic [2:0] REG_ROT_X  = 3'd3;
   localparam logic [2:0] REG_ROT_Y  = 3'd4;
   localparam logic [2:0] REG_ROT_Z  = 3'd5;

   localparam logic [31:0] ROT_RESET = 32'h4000_0000;

   typedef struct packed {
      logic               valid;
      logic               kind;
      logic [12:0]        idx;
      logic signed [7:0]  nx;
      logic signed [7:0]  ny;
      logic signed [7:0]  nz;
      logic signed [23:0] dx;
      logic signed [23:0] dy;
      logic signed [23:0] dz;
   } stage_type;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
   } vec_type;

   function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
      logic signed [23:0] r;
      if (v > 32'sd8388607) begin
         r = 24'sd8388607;
      end else if (v < -32'sd8388608) begin
         r = -24'sd8388608;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

/* rtl/spt_ram.sv */
// ----------------------------------------------------------------------------
// spt_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module spt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/spt_rot.sv */
// ----------------------------------------------------------------------------
// spt_rot
// One plane rotation with Q1.14 cosine/sine, two stages: products, then
// rounded and saturated sums.
// ----------------------------------------------------------------------------
module spt_rot import spt_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [23:0] a,
   input  logic signed [23:0] b,
   input  logic [31:0]        pair,
   output logic signed [23:0] a_rot,
   output logic signed [23:0] b_rot
);

   logic signed [15:0] cos_v;
   logic signed [15:0] sin_v;
   logic signed [39:0] ac_ff, bs_ff, bc_ff, as_ff;
   logic signed [40:0] ta, tb;
   logic signed [40:0] qa, qb;
   logic signed [23:0] a_ff, b_ff;

   assign cos_v = signed'(pair[31:16]);
   assign sin_v = signed'(pair[15:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         ac_ff <= a * cos_v;
         bs_ff <= b * sin_v;
         bc_ff <= b * cos_v;
         as_ff <= a * sin_v;
      end
   end

   // Round to nearest with ties upward: add half, then floor by the shift.
   assign ta = 41'(ac_ff) - 41'(bs_ff) + 41'sd8192;
   assign tb = 41'(bc_ff) + 41'(as_ff) + 41'sd8192;
   assign qa = ta >>> FRAC_BITS;
   assign qb = tb >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= sat24(32'(qa));
         b_ff <= sat24(32'(qb));
      end
   end

   assign a_rot = a_ff;
   assign b_rot = b_ff;

endmodule

/* rtl/spt_dist.sv */
// ----------------------------------------------------------------------------
// spt_dist
// Squared distance, respawn test and a pipelined integer square root that
// resolves two root bits per stage.
// ----------------------------------------------------------------------------
module spt_dist import spt_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [23:0] pos_x,
   input  logic signed [23:0] pos_y,
   input  logic signed [23:0] pos_z,
   output logic [23:0]        root,
   output logic               respawn
);

   function automatic logic [50:0] sq_step(input logic [26:0] rem,
                                           input logic [23:0] rt,
                                           input logic [1:0]  pair);
      logic [26:0] r;
      logic [26:0] trial;
      logic [50:0] res;
      r     = {rem[24:0], pair};
      trial = {1'b0, rt, 2'b01};
      if (r >= trial) begin
         res = {r - trial, rt[22:0], 1'b1};
      end else begin
         res = {r, rt[22:0], 1'b0};
      end
      return res;
   endfunction

   logic signed [47:0] px, py, pz;
   logic [46:0] sqx_ff, sqy_ff, sqz_ff;
   logic [47:0] sum_in;
   logic [47:0] rad_ff  [SQRT_STAGES+1];
   logic [26:0] rem_ff  [SQRT_STAGES+1];
   logic [23:0] root_ff [SQRT_STAGES+1];
   logic        flag_ff [SQRT_STAGES+1];

   assign px = pos_x * pos_x;
   assign py = pos_y * pos_y;
   assign pz = pos_z * pos_z;

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= px[46:0];
         sqy_ff <= py[46:0];
         sqz_ff <= pz[46:0];
      end
   end

   assign sum_in = 48'(sqx_ff) + 48'(sqy_ff) + 48'(sqz_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= sum_in;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         flag_ff[0] <= sum_in > RESPAWN_SQ;
      end
   end

   for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_sqrt
      logic [50:0] s1, s2;
      assign s1 = sq_step(rem_ff[k-1], root_ff[k-1], rad_ff[k-1][47:46]);
      assign s2 = sq_step(s1[50:24], s1[23:0], rad_ff[k-1][45:44]);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= s2[50:24];
            root_ff[k] <= s2[23:0];
            rad_ff[k]  <= {rad_ff[k-1][43:0], 4'b0};
            flag_ff[k] <= flag_ff[k-1];
         end
      end
   end

   assign root    = root_ff[SQRT_STAGES];
   assign respawn = flag_ff[SQRT_STAGES];

endmodule

/* rtl/spt_bright.sv */
// ----------------------------------------------------------------------------
// spt_bright
// Brightness divider: saturation check, then two quotient bits per stage.
// ----------------------------------------------------------------------------
module spt_bright import spt_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [23:0] root,
   input  logic        respawn,
   output logic [7:0]  bright,
   output logic        respawn_dly
);

   function automatic logic [30:0] div_step(input logic [29:0] rem,
                                            input logic [31:0] dv);
      logic [30:0] res;
      if ({2'b0, rem} >= dv) begin
         res = {1'b1, rem - dv[29:0]};
      end else begin
         res = {1'b0, rem};
      end
      return res;
   endfunction

   logic [23:0] d_ff   [DIV_STAGES+1];
   logic [29:0] rem_ff [DIV_STAGES+1];
   logic [7:0]  q_ff   [DIV_STAGES+1];
   logic        sat_ff [DIV_STAGES+1];
   logic        flag_ff[DIV_STAGES+1];
   logic        sat_in;

   // The quotient only fits in eight bits when 256 * d exceeds the numerator.
   assign sat_in = (root == '0) || ({root, 8'b0} <= {2'b0, BRIGHT_NUM});

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0]    <= root;
         rem_ff[0]  <= BRIGHT_NUM;
         q_ff[0]    <= '0;
         sat_ff[0]  <= sat_in;
         flag_ff[0] <= respawn;
      end
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      logic [30:0] s1, s2;
      logic [7:0]  q_in;
      assign s1 = div_step(rem_ff[k-1], {8'b0, d_ff[k-1]} << (9 - 2 * k));
      assign s2 = div_step(s1[29:0], {8'b0, d_ff[k-1]} << (8 - 2 * k));
      always_comb begin
         q_in = q_ff[k-1];
         q_in[9-2*k] = s1[30];
         q_in[8-2*k] = s2[30];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[k]    <= d_ff[k-1];
            rem_ff[k]  <= s2[29:0];
            q_ff[k]    <= q_in;
            sat_ff[k]  <= sat_ff[k-1];
            flag_ff[k] <= flag_ff[k-1];
         end
      end
   end

   assign bright      = sat_ff[DIV_STAGES] ? 8'hFF : q_ff[DIV_STAGES];
   assign respawn_dly = flag_ff[DIV_STAGES];

endmodule

/* rtl/star_point_translate_rotate.sv */
// ----------------------------------------------------------------------------
// star_point_translate_rotate
// Star memory with per-word translate, distance brightness and x-y-z rotation.
// ----------------------------------------------------------------------------
// Usage: one request word enters per cycle unless the result side stalls or
// a hazard holds it off; advance words give a result and load words give none.
// The pipeline depth is set by the square root (twelve stages) and the
// brightness divider (five stages) behind the star memory read and translate.
// Every word writes its star back at the end of the pipeline, so a word
// addressing a star that is still in flight is held off until that write-back
// is done. Rotation pairs and motion registers must be written while idle.
module star_point_translate_rotate import spt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // star_index[12:0], new_x[20:13], new_y[28:21], new_z[36:29], zero fill
   input  logic [39:0] req_tdata,
   // req_type[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_index[12:0], draw_x[36:13], draw_y[60:37], draw_z[84:61],
   // brightness[92:85], zero fill
   output logic [95:0] rsp_tdata,
   // respawned[0]
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic signed [23:0] move_x_ff, move_y_ff, move_z_ff;
   logic [31:0]        rot_x_ff, rot_y_ff, rot_z_ff;

   logic        en;
   logic        hazard;
   logic        in_range;
   stage_type   a_ff, a_in, b_ff, c_ff, c_in;
   stage_type   line_ff [1:LINE_DEPTH];
   logic [71:0] ram_rd_data;
   logic        wr_en;
   logic [71:0] wr_data;

   logic signed [23:0] y1, z1, z2, x2, x3, y3;
   logic signed [23:0] xd_ff [2];
   logic signed [23:0] yd_ff [2];
   logic signed [23:0] zd_ff [2];
   vec_type            rd_ff [ROT_PAD];

   logic [23:0] root;
   logic        respawn_sq;
   logic [7:0]  bright;
   logic        respawn;

   logic        rsp_tvalid_ff;
   logic [95:0] rsp_tdata_ff;
   logic        rsp_tuser_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         move_x_ff <= '0;
         move_y_ff <= '0;
         move_z_ff <= '0;
         rot_x_ff  <= ROT_RESET;
         rot_y_ff  <= ROT_RESET;
         rot_z_ff  <= ROT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MOVE_X: move_x_ff <= signed'(csr_wdata[23:0]);
            REG_MOVE_Y: move_y_ff <= signed'(csr_wdata[23:0]);
            REG_MOVE_Z: move_z_ff <= signed'(csr_wdata[23:0]);
            REG_ROT_X:  rot_x_ff  <= csr_wdata;
            REG_ROT_Y:  rot_y_ff  <= csr_wdata;
            REG_ROT_Z:  rot_z_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en = !rsp_tvalid_ff || rsp_tready;

   // A word may not read a star whose write-back is still pending.
   always_comb begin
      hazard = (a_ff.valid && a_ff.idx == req_tdata[12:0])
            || (b_ff.valid && b_ff.idx == req_tdata[12:0])
            || (c_ff.valid && c_ff.idx == req_tdata[12:0]);
      for (int k = 1; k <= LINE_DEPTH; k++) begin
         if (line_ff[k].valid && line_ff[k].idx == req_tdata[12:0]) begin
            hazard = 1'b1;
         end
      end
   end

   assign req_tready = en && !hazard;
   assign in_range   = 32'(req_tdata[12:0]) < STAR_COUNT;

   always_comb begin
      a_in       = '0;
      a_in.valid = req_tvalid && !hazard && in_range;
      a_in.kind  = req_tuser;
      a_in.idx   = req_tdata[12:0];
      a_in.nx    = signed'(req_tdata[20:13]);
      a_in.ny    = signed'(req_tdata[28:21]);
      a_in.nz    = signed'(req_tdata[36:29]);
   end

   spt_ram #(.WIDTH(72), .DEPTH(STAR_COUNT)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (STAR_ADDR_W'(line_ff[LINE_DEPTH].idx)),
      .wr_data (wr_data),
      .rd_en   (en),
      .rd_addr (STAR_ADDR_W'(a_ff.idx)),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      c_in    = b_ff;
      c_in.dx = sat24(32'(signed'(ram_rd_data[23:0])) - 32'(move_x_ff));
      c_in.dy = sat24(32'(signed'(ram_rd_data[47:24])) - 32'(move_y_ff));
      c_in.dz = sat24(32'(signed'(ram_rd_data[71:48])) - 32'(move_z_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
         for (int k = 1; k <= LINE_DEPTH; k++) begin
            line_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         a_ff       <= a_in;
         b_ff       <= a_ff;
         c_ff       <= c_in;
         line_ff[1] <= c_ff;
         for (int k = 2; k <= LINE_DEPTH; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   // Rotation about x, then y, then z.
   spt_rot u_rot_x (
      .clock (clock), .en (en), .a (c_ff.dy), .b (c_ff.dz), .pair (rot_x_ff),
      .a_rot (y1), .b_rot (z1)
   );

   spt_rot u_rot_y (
      .clock (clock), .en (en), .a (z1), .b (xd_ff[1]), .pair (rot_y_ff),
      .a_rot (z2), .b_rot (x2)
   );

   spt_rot u_rot_z (
      .clock (clock), .en (en), .a (x2), .b (yd_ff[1]), .pair (rot_z_ff),
      .a_rot (x3), .b_rot (y3)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         xd_ff[0] <= c_ff.dx;
         xd_ff[1] <= xd_ff[0];
         yd_ff[0] <= y1;
         yd_ff[1] <= yd_ff[0];
         zd_ff[0] <= z2;
         zd_ff[1] <= zd_ff[0];
         rd_ff[0] <= '{x: x3, y: y3, z: zd_ff[1]};
         for (int k = 1; k < ROT_PAD; k++) begin
            rd_ff[k] <= rd_ff[k-1];
         end
      end
   end

   spt_dist u_dist (
      .clock   (clock),
      .en      (en),
      .pos_x   (c_ff.dx),
      .pos_y   (c_ff.dy),
      .pos_z   (c_ff.dz),
      .root    (root),
      .respawn (respawn_sq)
   );

   spt_bright u_bright (
      .clock       (clock),
      .en          (en),
      .root        (root),
      .respawn     (respawn_sq),
      .bright      (bright),
      .respawn_dly (respawn)
   );

   // Write-back: loads and respawns store the word's coordinates, other advances the rotated position.
   always_comb begin
      if (line_ff[LINE_DEPTH].kind == KIND_LOAD || respawn) begin
         wr_data = {24'(signed'({line_ff[LINE_DEPTH].nz, 14'b0})),
                    24'(signed'({line_ff[LINE_DEPTH].ny, 14'b0})),
                    24'(signed'({line_ff[LINE_DEPTH].nx, 14'b0}))};
      end else begin
         wr_data = {rd_ff[ROT_PAD-1].z, rd_ff[ROT_PAD-1].y, rd_ff[ROT_PAD-1].x};
      end
   end

   assign wr_en = en && line_ff[LINE_DEPTH].valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= line_ff[LINE_DEPTH].valid
                       && line_ff[LINE_DEPTH].kind == KIND_ADVANCE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= {3'b0, bright, line_ff[LINE_DEPTH].dz,
                          line_ff[LINE_DEPTH].dy, line_ff[LINE_DEPTH].dx,
                          line_ff[LINE_DEPTH].idx};
         rsp_tuser_ff <= respawn;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

/* sim/star_point_translate_rotate_checker.sv */
// ----------------------------------------------------------------------------
// star_point_translate_rotate_checker
// Watches the request, result and register ports of the star block, keeps its
// own copy of the star memory and settings, predicts every advance result and
// compares each result field by field in order.
// ----------------------------------------------------------------------------
module star_point_translate_rotate_checker import spt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          outstanding,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [12:0]        idx;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic [7:0]         bright;
      logic               respawned;
   } star_result_type;

   logic signed [23:0] pos_x [STAR_COUNT];
   logic signed [23:0] pos_y [STAR_COUNT];
   logic signed [23:0] pos_z [STAR_COUNT];
   logic signed [23:0] motion_x, motion_y, motion_z;
   logic [31:0]        turn_x, turn_y, turn_z;
   star_result_type    pending_results [$];
   int                 errors;

   function automatic logic signed [23:0] clamp24(input longint v);
      if (v > 64'sd8388607) return 24'sd8388607;
      if (v < -64'sd8388608) return -24'sd8388608;
      return v[23:0];
   endfunction

   // Round half up, then drop the 14 fraction bits.
   function automatic logic signed [23:0] round_frac(input longint v);
      return clamp24((v + 64'sd8192) >>> 14);
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned root, bit_pos;
      root = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > n) bit_pos = bit_pos >> 2;
      while (bit_pos != 0) begin
         if (n >= root + bit_pos) begin
            n = n - (root + bit_pos);
            root = (root >> 1) + bit_pos;
         end else begin
            root = root >> 1;
         end
         bit_pos = bit_pos >> 2;
      end
      return root;
   endfunction

   // Plane rotation: a' = a*c - b*s, b' = b*c + a*s.
   function automatic void turn_plane(inout logic signed [23:0] a,
                                      inout logic signed [23:0] b,
                                      input logic [31:0] pair);
      longint c, s, av, bv;
      c = longint'($signed(pair[31:16]));
      s = longint'($signed(pair[15:0]));
      av = longint'(a);
      bv = longint'(b);
      a = round_frac(av * c - bv * s);
      b = round_frac(bv * c + av * s);
   endfunction

   function automatic void predict_word(input logic kind, input logic [12:0] idx,
                                        input logic signed [7:0] nx,
                                        input logic signed [7:0] ny,
                                        input logic signed [7:0] nz);
      logic signed [23:0] x, y, z, sx, sy, sz;
      longint unsigned    sumsq, radius, level;
      star_result_type    r;
      sx = 24'(longint'(nx) * 16384);
      sy = 24'(longint'(ny) * 16384);
      sz = 24'(longint'(nz) * 16384);
      if (kind == KIND_LOAD) begin
         pos_x[idx] = sx;
         pos_y[idx] = sy;
         pos_z[idx] = sz;
         return;
      end
      x = clamp24(longint'(pos_x[idx]) - longint'(motion_x));
      y = clamp24(longint'(pos_y[idx]) - longint'(motion_y));
      z = clamp24(longint'(pos_z[idx]) - longint'(motion_z));
      sumsq = longint'(x) * longint'(x) + longint'(y) * longint'(y)
            + longint'(z) * longint'(z);
      radius = floor_sqrt(sumsq);
      if (radius == 0) begin
         level = 255;
      end else begin
         level = longint'(BRIGHT_NUM) / radius;
         if (level > 255) level = 255;
      end
      r.idx = idx;
      r.x = x;
      r.y = y;
      r.z = z;
      r.bright = level[7:0];
      r.respawned = sumsq > longint'(RESPAWN_SQ);
      pending_results.push_back(r);
      if (r.respawned) begin
         pos_x[idx] = sx;
         pos_y[idx] = sy;
         pos_z[idx] = sz;
      end else begin
         turn_plane(y, z, turn_x);
         turn_plane(z, x, turn_y);
         turn_plane(x, y, turn_z);
         pos_x[idx] = x;
         pos_y[idx] = y;
         pos_z[idx] = z;
      end
   endfunction

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      star_result_type want, got;
      if (reset) begin
         motion_x = '0;
         motion_y = '0;
         motion_z = '0;
         turn_x = ROT_RESET;
         turn_y = ROT_RESET;
         turn_z = ROT_RESET;
         pending_results.delete();
         errors = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.idx = rsp_tdata[12:0];
            got.x = rsp_tdata[36:13];
            got.y = rsp_tdata[60:37];
            got.z = rsp_tdata[84:61];
            got.bright = rsp_tdata[92:85];
            got.respawned = rsp_tuser;
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none actual %h", $time, got);
            end else begin
               want = pending_results.pop_front();
               compare_field("out_index", want.idx, got.idx);
               compare_field("draw_x", want.x, got.x);
               compare_field("draw_y", want.y, got.y);
               compare_field("draw_z", want.z, got.z);
               compare_field("brightness", want.bright, got.bright);
               compare_field("respawned", want.respawned, got.respawned);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_word(req_tuser, req_tdata[12:0], req_tdata[20:13],
                         req_tdata[28:21], req_tdata[36:29]);
         end
         if (csr_we) begin
            case (csr_index)
               REG_MOVE_X: motion_x = csr_wdata[23:0];
               REG_MOVE_Y: motion_y = csr_wdata[23:0];
               REG_MOVE_Z: motion_z = csr_wdata[23:0];
               REG_ROT_X:  turn_x = csr_wdata;
               REG_ROT_Y:  turn_y = csr_wdata;
               REG_ROT_Z:  turn_z = csr_wdata;
               default: ;
            endcase
         end
      end
      outstanding <= pending_results.size();
      fail_count <= errors;
   end

endmodule

/* sim/tb_star_point_translate_rotate.sv */
// ----------------------------------------------------------------------------
// tb_star_point_translate_rotate
// Drives load and advance words into the star block under random idling on
// both channels, changes motion and rotation settings between idle phases and
// takes the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_star_point_translate_rotate import spt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_WORDS = 155;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int          outstanding;
   int          fail_count;
   int          cycles = 0;
   logic        req_calm = 1'b0;
   logic        rsp_calm = 1'b0;
   logic        loaded [STAR_COUNT];

   always #6 clock = ~clock;

   star_point_translate_rotate i_dut (.*);

   star_point_translate_rotate_checker i_checker (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: a random stall before each word, none in calm stretches.
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = rsp_calm ? 0 : $urandom_range(0, 18);
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic send_word(input logic kind, input logic [12:0] idx,
                            input logic signed [7:0] nx, input logic signed [7:0] ny,
                            input logic signed [7:0] nz);
      int n;
      n = req_calm ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {3'b000, nz, ny, nx, idx};
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_LOAD) loaded[idx] = 1'b1;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // Load words leave no result to wait for, so cover the pipeline depth.
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(input logic [23:0] mx, input logic [23:0] my,
                            input logic [23:0] mz, input logic [31:0] rx,
                            input logic [31:0] ry, input logic [31:0] rz);
      write_reg(REG_MOVE_X, {8'h00, mx});
      write_reg(REG_MOVE_Y, {8'h00, my});
      write_reg(REG_MOVE_Z, {8'h00, mz});
      write_reg(REG_ROT_X, rx);
      write_reg(REG_ROT_Y, ry);
      write_reg(REG_ROT_Z, rz);
   endtask

   function automatic logic signed [7:0] coord();
      return 8'($signed($urandom_range(0, 199)) - 100);
   endfunction

   function automatic logic [23:0] small_motion();
      return 24'(int'($urandom_range(0, 6 * 16384)) - 3 * 16384);
   endfunction

   // Mostly a small set of stars so that words hit stars still in flight.
   task automatic random_phase(input int count);
      logic [12:0] idx;
      for (int i = 0; i < count; i++) begin
         idx = ($urandom_range(0, 9) < 7) ? 13'($urandom_range(0, 15))
                                          : 13'($urandom_range(0, STAR_COUNT - 1));
         if (!loaded[idx] || $urandom_range(0, 99) < 30) begin
            send_word(KIND_LOAD, idx, coord(), coord(), coord());
         end else begin
            send_word(KIND_ADVANCE, idx, coord(), coord(), coord());
         end
      end
   endtask

   initial begin
      foreach (loaded[i]) loaded[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: field extremes, zero distance, exact respawn boundary.
      send_word(KIND_LOAD, 13'd0, 8'sd99, 8'sd99, 8'sd99);
      send_word(KIND_ADVANCE, 13'd0, -8'sd100, 8'sd99, 8'sd0);
      send_word(KIND_LOAD, 13'd8191, -8'sd100, -8'sd100, -8'sd100);
      send_word(KIND_ADVANCE, 13'd8191, 8'sd1, -8'sd1, 8'sd5);
      send_word(KIND_LOAD, 13'd1, 8'sd0, 8'sd0, 8'sd0);
      send_word(KIND_ADVANCE, 13'd1, 8'sd7, 8'sd8, 8'sd9);
      send_word(KIND_LOAD, 13'd2, 8'sd60, 8'sd80, 8'sd0);
      send_word(KIND_ADVANCE, 13'd2, 8'sd3, 8'sd3, 8'sd3);
      send_word(KIND_LOAD, 13'd3, 8'sd60, 8'sd80, 8'sd1);
      send_word(KIND_ADVANCE, 13'd3, -8'sd100, -8'sd100, -8'sd100);
      send_word(KIND_LOAD, 13'd4, 8'sd57, -8'sd57, 8'sd57);
      send_word(KIND_ADVANCE, 13'd4, 8'sd0, 8'sd0, 8'sd0);
      send_word(KIND_ADVANCE, 13'd4, 8'sd0, 8'sd0, 8'sd0);
      send_word(KIND_ADVANCE, 13'd2, 8'sd0, 8'sd0, 8'sd0);
      random_phase(PHASE_WORDS);
      settle();

      // Unit step toward -x makes x = 100 exactly, which must not respawn.
      write_all(-24'sd16384, 24'd0, 24'd0, ROT_RESET, ROT_RESET, ROT_RESET);
      req_calm = 1'b1;
      send_word(KIND_LOAD, 13'd5, 8'sd99, 8'sd0, 8'sd0);
      send_word(KIND_ADVANCE, 13'd5, 8'sd1, 8'sd1, 8'sd1);
      send_word(KIND_ADVANCE, 13'd5, 8'sd1, 8'sd1, 8'sd1);
      random_phase(PHASE_WORDS);
      settle();

      // Proper rotations: 45 degrees, -30 degrees, 90 degrees.
      req_calm = 1'b0;
      rsp_calm = 1'b1;
      write_all(24'd0, 24'd0, 24'd32768, 32'h2D41_2D41, 32'h376D_E000, 32'h0000_4000);
      random_phase(PHASE_WORDS);
      settle();

      // Extremes: saturating motion and full-scale cosine/sine values.
      rsp_calm = 1'b0;
      write_all(24'h7FFFFF, 24'h800000, 24'd0, 32'h7FFF_7FFF, 32'h8000_8000,
                32'hFFFF_0001);
      random_phase(PHASE_WORDS / 2);
      settle();
      write_all(24'd0, 24'd0, 24'd0, 32'h8000_7FFF, 32'h7FFF_8000, 32'h0000_0000);
      random_phase(PHASE_WORDS / 2);
      settle();

      for (int p = 0; p < 3; p++) begin
         req_calm = (p == 1);
         rsp_calm = (p == 1);
         write_all(small_motion(), small_motion(), small_motion(),
                   $urandom(), $urandom(), $urandom());
         random_phase(PHASE_WORDS);
         settle();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* star_point_translate_rotate.f */
rtl/spt_pkg.sv
rtl/spt_ram.sv
rtl/spt_rot.sv
rtl/spt_dist.sv
rtl/spt_bright.sv
rtl/star_point_translate_rotate.sv
sim/star_point_translate_rotate_checker.sv
sim/tb_star_point_translate_rotate.sv
